[src/nhps_pkg.sv]
package nhps_pkg;

    // Fixed-point format: signed Q(31-FRAC_BITS).FRAC_BITS throughout.
    localparam int FRAC_BITS = 16;
    // Quotient bits of the inverse-transpose division: |cof| << FRAC_BITS over |det|.
    localparam int QBITS     = 32 + FRAC_BITS;
    // Width of the integer part of log2(J), two's complement.
    localparam int LOG_IW    = 7;
    // Entries of a 3x3 matrix.
    localparam int NLANE     = 9;
    // ln(2) scaled by 2^32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_JAC  = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    // One particle request.
    typedef struct packed {
        logic signed [31:0] f_11;
        logic signed [31:0] f_12;
        logic signed [31:0] f_13;
        logic signed [31:0] f_21;
        logic signed [31:0] f_22;
        logic signed [31:0] f_23;
        logic signed [31:0] f_31;
        logic signed [31:0] f_32;
        logic signed [31:0] f_33;
        logic signed [31:0] jacobian;
        logic [30:0]        shear_modulus;
        logic [30:0]        lame_lambda;
    } particle_t;

    // One stress result.
    typedef struct packed {
        logic signed [31:0] p_11;
        logic signed [31:0] p_12;
        logic signed [31:0] p_13;
        logic signed [31:0] p_21;
        logic signed [31:0] p_22;
        logic signed [31:0] p_23;
        logic signed [31:0] p_31;
        logic signed [31:0] p_32;
        logic signed [31:0] p_33;
        logic signed [31:0] energy;
        status_t            status;
    } stress_t;

    // Values that travel alongside the divider untouched.
    typedef struct packed {
        status_t                 status;
        logic [NLANE-1:0][31:0]  a;
        logic [30:0]             mu;
        logic [31:0]             c;
        logic [31:0]             psi;
    } side_t;

    // Divider input: nine cofactors over one determinant.
    typedef struct packed {
        logic [NLANE-1:0][31:0]  cof;
        logic [31:0]             det;
        side_t                   side;
    } div_req_t;

    // Divider stage contents; after the last step quo holds the quotient.
    typedef struct packed {
        logic [NLANE-1:0][QBITS-1:0] quo;
        logic [NLANE-1:0][31:0]      rem;
        logic [NLANE-1:0]            neg;
        logic [31:0]                 den;
        side_t                       side;
    } div_rsp_t;

    // Right shift by s bits, rounding to nearest with ties away from zero.
    function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] x,
                                                   input int unsigned s);
        logic [79:0] m;
        m = x[79] ? -x : x;
        m = (m + (80'd1 << (s - 1))) >> s;
        return x[79] ? -$signed(m) : $signed(m);
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
        logic signed [31:0] r;
        if (x > 80'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -80'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

[src/neo_hookean_piola_stress.sv]
// Neo-Hookean first Piola stress and strain energy, one particle per request.
// Input channel particle/particle_valid/particle_stall carries F, J, mu and
// lambda; output channel stress/stress_valid/stress_stall returns the nine
// stress entries, the energy density and a status code.
// A request is taken at a rising edge with valid high and stall low.
// Throughput is one request per cycle while particle_stall is low. The
// pipeline runs through the FRAC_BITS squaring steps of the logarithm and
// the 32+FRAC_BITS one-bit steps of the cofactor divider.
// The whole pipeline advances together: when the result register holds a
// request that the receiver stalls, particle_stall rises in the same cycle
// and every stage holds its contents, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is then empty and ready.
// A status of bad Jacobian or singular F returns zero stress and energy.
module neo_hookean_piola_stress (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                particle_valid,
    output logic                particle_stall,
    input  nhps_pkg::particle_t particle,
    output logic                stress_valid,
    input  logic                stress_stall,
    output nhps_pkg::stress_t   stress
);
    import nhps_pkg::*;

    localparam int NMID = FRAC_BITS + 7;

    typedef struct packed {
        logic [NLANE-1:0][31:0] a;
        logic [NLANE-1:0][63:0] pp;
        logic [NLANE-1:0][63:0] pm;
        logic [NLANE-1:0][63:0] sq;
        logic [31:0]            jac;
        logic [30:0]            mu;
        logic [30:0]            lam;
    } s1_t;

    typedef struct packed {
        logic [NLANE-1:0][31:0] a;
        logic [NLANE-1:0][31:0] cof;
        logic [2:0][63:0]       tp;
        logic [31:0]            m;
        logic [LOG_IW-1:0]      ip;
        logic                   badj;
        logic [30:0]            mu;
        logic [30:0]            lam;
    } s2_t;

    typedef struct packed {
        logic [NLANE-1:0][31:0] a;
        logic [NLANE-1:0][31:0] cof;
        logic [2:0][63:0]       dp;
        logic [31:0]            t;
        logic [31:0]            m;
        logic [LOG_IW-1:0]      ip;
        logic                   badj;
        logic [30:0]            mu;
        logic [30:0]            lam;
    } s3_t;

    typedef struct packed {
        status_t                status;
        logic [NLANE-1:0][31:0] a;
        logic [NLANE-1:0][31:0] cof;
        logic [31:0]            det;
        logic [31:0]            t;
        logic [31:0]            m;
        logic [FRAC_BITS-1:0]   frac;
        logic [LOG_IW-1:0]      ip;
        logic [31:0]            ln;
        logic [31:0]            c;
        logic [31:0]            l2;
        logic [31:0]            psi;
        logic [3:0][63:0]       w;
        logic [63:0]            e1;
        logic [30:0]            mu;
        logic [30:0]            lam;
    } mid_t;

    typedef struct packed {
        status_t                status;
        logic [NLANE-1:0][31:0] a;
        logic [NLANE-1:0][31:0] g;
        logic [30:0]            mu;
        logic [31:0]            c;
        logic [31:0]            psi;
    } p1_t;

    typedef struct packed {
        status_t                status;
        logic [NLANE-1:0][32:0] diff;
        logic [NLANE-1:0][31:0] g;
        logic [30:0]            mu;
        logic [31:0]            c;
        logic [31:0]            psi;
    } p2_t;

    typedef struct packed {
        status_t                status;
        logic [NLANE-1:0][63:0] pa;
        logic [NLANE-1:0][63:0] pc;
        logic [31:0]            psi;
    } p3_t;

    logic                   en;
    logic [NLANE-1:0][31:0] fin;
    logic [NLANE-1:0][63:0] pp_w;
    logic [NLANE-1:0][63:0] pm_w;

    logic      s1_vld_reg, s2_vld_reg, s3_vld_reg;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    logic [NMID-1:0] mid_vld_reg;
    mid_t      mid_reg  [NMID];
    mid_t      mid_next [NMID];
    div_req_t  div_req;
    logic      div_vld;
    div_rsp_t  div_rsp;
    logic      p1_vld_reg, p2_vld_reg, p3_vld_reg, out_vld_reg;
    p1_t       p1_reg, p1_next;
    p2_t       p2_reg, p2_next;
    p3_t       p3_reg, p3_next;
    stress_t   out_reg, out_next;

    // The pipeline advances unless a finished result is being held.
    assign particle_stall = out_vld_reg && stress_stall;
    assign en             = !particle_stall;

    assign fin = {particle.f_33, particle.f_32, particle.f_31,
                  particle.f_23, particle.f_22, particle.f_21,
                  particle.f_13, particle.f_12, particle.f_11};

    // Stage 1: the two products of each cofactor, and the squares for the trace.
    for (genvar gi = 0; gi < 3; gi++)
    begin : g_row
        for (genvar gk = 0; gk < 3; gk++)
        begin : g_col
            localparam int R1 = (gi + 1) % 3;
            localparam int R2 = (gi + 2) % 3;
            localparam int C1 = (gk + 1) % 3;
            localparam int C2 = (gk + 2) % 3;
            assign pp_w[gi*3+gk] = $signed(fin[R1*3+C1]) * $signed(fin[R2*3+C2]);
            assign pm_w[gi*3+gk] = $signed(fin[R1*3+C2]) * $signed(fin[R2*3+C1]);
        end
    end

    always_comb
    begin
        s1_next.a   = fin;
        s1_next.pp  = pp_w;
        s1_next.pm  = pm_w;
        s1_next.jac = particle.jacobian;
        s1_next.mu  = particle.shear_modulus;
        s1_next.lam = particle.lame_lambda;
        for (int n = 0; n < NLANE; n++)
            s1_next.sq[n] = $signed(fin[n]) * $signed(fin[n]);
    end

    // Stage 2: cofactors, rounded squares summed per row, and normalisation
    // of J for the logarithm.
    always_comb
    begin : st2
        logic [4:0]         p;
        s2_next.a   = s1_reg.a;
        s2_next.mu  = s1_reg.mu;
        s2_next.lam = s1_reg.lam;
        for (int n = 0; n < NLANE; n++)
            s2_next.cof[n] = sat32(rnd_shr(80'($signed(s1_reg.pp[n]))
                                           - 80'($signed(s1_reg.pm[n])), FRAC_BITS));
        for (int r = 0; r < 3; r++)
            s2_next.tp[r] = 64'(rnd_shr(80'($signed(s1_reg.sq[r*3])), FRAC_BITS)
                                + rnd_shr(80'($signed(s1_reg.sq[r*3+1])), FRAC_BITS)
                                + rnd_shr(80'($signed(s1_reg.sq[r*3+2])), FRAC_BITS));
        p = '0;
        for (int b = 1; b < 31; b++)
            if (s1_reg.jac[b])
                p = 5'(b);
        s2_next.m    = {1'b0, s1_reg.jac[30:0]} << (5'd30 - p);
        s2_next.ip   = LOG_IW'(p) - LOG_IW'(FRAC_BITS);
        s2_next.badj = s1_reg.jac[31] || (s1_reg.jac == '0);
    end

    // Stage 3: products of the first row with its cofactors, and the trace term.
    always_comb
    begin
        s3_next.a    = s2_reg.a;
        s3_next.cof  = s2_reg.cof;
        s3_next.t    = sat32(80'($signed(s2_reg.tp[0])) + 80'($signed(s2_reg.tp[1]))
                             + 80'($signed(s2_reg.tp[2])) - (80'sd3 << FRAC_BITS));
        s3_next.m    = s2_reg.m;
        s3_next.ip   = s2_reg.ip;
        s3_next.badj = s2_reg.badj;
        s3_next.mu   = s2_reg.mu;
        s3_next.lam  = s2_reg.lam;
        for (int k = 0; k < 3; k++)
            s3_next.dp[k] = $signed(s2_reg.a[k]) * $signed(s2_reg.cof[k]);
    end

    // Middle stage 0: determinant and status.
    always_comb
    begin : det_stage
        logic signed [79:0] det80;
        mid_next[0]        = '0;
        mid_next[0].a      = s3_reg.a;
        mid_next[0].cof    = s3_reg.cof;
        mid_next[0].t      = s3_reg.t;
        mid_next[0].m      = s3_reg.m;
        mid_next[0].ip     = s3_reg.ip;
        mid_next[0].mu     = s3_reg.mu;
        mid_next[0].lam    = s3_reg.lam;
        det80 = '0;
        for (int k = 0; k < 3; k++)
            det80 = det80 + rnd_shr(80'($signed(s3_reg.dp[k])), FRAC_BITS);
        mid_next[0].det = sat32(det80);
        if (s3_reg.badj)
            mid_next[0].status = ST_BAD_JAC;
        else if (mid_next[0].det == '0)
            mid_next[0].status = ST_SINGULAR;
        else
            mid_next[0].status = ST_OK;
    end

    // Middle stages: logarithm by repeated squaring, then the energy terms.
    for (genvar k = 1; k < NMID; k++)
    begin : g_mid
        if (k <= FRAC_BITS)
        begin : g_log
            // Square the mantissa; a carry into bit 31 gives the next log2 bit.
            always_comb
            begin : log_step
                logic [63:0] sq;
                logic [31:0] mn;
                mid_next[k] = mid_reg[k-1];
                sq = mid_reg[k-1].m * mid_reg[k-1].m;
                mn = sq[61:30];
                if (mn[31])
                begin
                    mid_next[k].m                 = {1'b0, mn[31:1]};
                    mid_next[k].frac[FRAC_BITS-k] = 1'b1;
                end
                else
                begin
                    mid_next[k].m = mn;
                end
            end
        end
        else if (k == FRAC_BITS + 1)
        begin : g_lg
            // Scale log2 by ln 2.
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].w[0] = $signed({mid_reg[k-1].ip, mid_reg[k-1].frac})
                                   * $signed({1'b0, LN2_Q32});
            end
        end
        else if (k == FRAC_BITS + 2)
        begin : g_ln
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].ln = sat32(rnd_shr(80'($signed(mid_reg[k-1].w[0])), 32));
            end
        end
        else if (k == FRAC_BITS + 3)
        begin : g_eprod
            // Products with ln J and the trace term.
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].w[0] = $signed({1'b0, mid_reg[k-1].lam}) * $signed(mid_reg[k-1].ln);
                mid_next[k].w[1] = $signed(mid_reg[k-1].ln) * $signed(mid_reg[k-1].ln);
                mid_next[k].w[2] = $signed({1'b0, mid_reg[k-1].mu}) * $signed(mid_reg[k-1].ln);
                mid_next[k].w[3] = $signed({1'b0, mid_reg[k-1].mu}) * $signed(mid_reg[k-1].t);
            end
        end
        else if (k == FRAC_BITS + 4)
        begin : g_coef
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].c  = sat32(rnd_shr(80'($signed(mid_reg[k-1].w[0])), FRAC_BITS));
                mid_next[k].l2 = sat32(rnd_shr(80'($signed(mid_reg[k-1].w[1])), FRAC_BITS));
                mid_next[k].e1 = 64'(rnd_shr(80'($signed(mid_reg[k-1].w[3])), FRAC_BITS + 1)
                                     - rnd_shr(80'($signed(mid_reg[k-1].w[2])), FRAC_BITS));
            end
        end
        else if (k == FRAC_BITS + 5)
        begin : g_lamprod
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].w[0] = $signed({1'b0, mid_reg[k-1].lam}) * $signed(mid_reg[k-1].l2);
            end
        end
        else
        begin : g_psi
            always_comb
            begin
                mid_next[k] = mid_reg[k-1];
                mid_next[k].psi = sat32(80'($signed(mid_reg[k-1].e1))
                                        + rnd_shr(80'($signed(mid_reg[k-1].w[0])),
                                                  FRAC_BITS + 1));
            end
        end
    end

    // Inverse transpose: every cofactor over the determinant.
    always_comb
    begin
        div_req.cof         = mid_reg[NMID-1].cof;
        div_req.det         = mid_reg[NMID-1].det;
        div_req.side.status = mid_reg[NMID-1].status;
        div_req.side.a      = mid_reg[NMID-1].a;
        div_req.side.mu     = mid_reg[NMID-1].mu;
        div_req.side.c      = mid_reg[NMID-1].c;
        div_req.side.psi    = mid_reg[NMID-1].psi;
    end

    nhps_qdiv_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (mid_vld_reg[NMID-1]),
        .req       (div_req),
        .rsp_valid (div_vld),
        .rsp       (div_rsp)
    );

    // Post stage 1: round the quotient, apply the sign and saturate.
    always_comb
    begin : post1
        logic             rup;
        logic [QBITS:0]   qr;
        p1_next.status = div_rsp.side.status;
        p1_next.a      = div_rsp.side.a;
        p1_next.mu     = div_rsp.side.mu;
        p1_next.c      = div_rsp.side.c;
        p1_next.psi    = div_rsp.side.psi;
        for (int l = 0; l < NLANE; l++)
        begin
            rup = {div_rsp.rem[l], 1'b0} >= {1'b0, div_rsp.den};
            qr  = {1'b0, div_rsp.quo[l]} + (QBITS+1)'(rup);
            p1_next.g[l] = sat32(div_rsp.neg[l] ? -80'(qr) : 80'(qr));
        end
    end

    // Post stage 2: F - F^-T.
    always_comb
    begin
        p2_next.status = p1_reg.status;
        p2_next.g      = p1_reg.g;
        p2_next.mu     = p1_reg.mu;
        p2_next.c      = p1_reg.c;
        p2_next.psi    = p1_reg.psi;
        for (int l = 0; l < NLANE; l++)
            p2_next.diff[l] = 33'($signed(p1_reg.a[l])) - 33'($signed(p1_reg.g[l]));
    end

    // Post stage 3: the shear and volume products.
    always_comb
    begin
        p3_next.status = p2_reg.status;
        p3_next.psi    = p2_reg.psi;
        for (int l = 0; l < NLANE; l++)
        begin
            p3_next.pa[l] = $signed({1'b0, p2_reg.mu}) * $signed(p2_reg.diff[l]);
            p3_next.pc[l] = $signed(p2_reg.c) * $signed(p2_reg.g[l]);
        end
    end

    // Result register: sum, saturate, and clear on a bad status.
    always_comb
    begin : post4
        logic [NLANE-1:0][31:0] pv;
        logic                   ok;
        ok = p3_reg.status == ST_OK;
        for (int l = 0; l < NLANE; l++)
            pv[l] = ok ? sat32(rnd_shr(80'($signed(p3_reg.pa[l])), FRAC_BITS)
                               + rnd_shr(80'($signed(p3_reg.pc[l])), FRAC_BITS)) : '0;
        out_next.p_11   = pv[0];
        out_next.p_12   = pv[1];
        out_next.p_13   = pv[2];
        out_next.p_21   = pv[3];
        out_next.p_22   = pv[4];
        out_next.p_23   = pv[5];
        out_next.p_31   = pv[6];
        out_next.p_32   = pv[7];
        out_next.p_33   = pv[8];
        out_next.energy = ok ? p3_reg.psi : '0;
        out_next.status = p3_reg.status;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            mid_vld_reg <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= particle_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            mid_vld_reg <= {mid_vld_reg[NMID-2:0], s3_vld_reg};
            p1_vld_reg  <= div_vld;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            out_vld_reg <= p3_vld_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            mid_reg <= mid_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            out_reg <= out_next;
        end
    end

    assign stress_valid = out_vld_reg;
    assign stress       = out_reg;

    // A bad status always comes with zero stress and energy.
    assert property (@(posedge clk) disable iff (!rst_n)
        stress_valid && stress.status != ST_OK
        |-> stress.energy == '0 && stress.p_11 == '0 && stress.p_33 == '0)
        else $error("stress: non-zero result with a bad status");

    // A non-positive Jacobian is flagged when the determinant is formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        en && s3_vld_reg && s3_reg.badj |=> mid_reg[0].status == ST_BAD_JAC)
        else $error("stress: bad Jacobian not flagged");

    // After the squaring steps the mantissa lies in [1, 2).
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_vld_reg[FRAC_BITS] && mid_reg[FRAC_BITS].status == ST_OK
        |-> mid_reg[FRAC_BITS].m[31:30] == 2'b01)
        else $error("stress: log mantissa out of range");

endmodule

[src/nhps_qdiv_pipe.sv]
module nhps_qdiv_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               req_valid,
    input  nhps_pkg::div_req_t req,
    output logic               rsp_valid,
    output nhps_pkg::div_rsp_t rsp
);
    import nhps_pkg::*;

    // One magnitude stage, then one restoring step per quotient bit.
    localparam int NST = QBITS + 1;

    logic [NST-1:0] vld_reg;
    div_rsp_t       st_reg  [NST];
    div_rsp_t       st_next [NST];

    // Magnitudes and result signs; the numerator is the cofactor scaled by 2^FRAC_BITS.
    always_comb
    begin
        st_next[0].side = req.side;
        st_next[0].den  = req.det[31] ? 32'(-req.det) : req.det;
        for (int l = 0; l < NLANE; l++)
        begin
            st_next[0].quo[l] = {(req.cof[l][31] ? 32'(-req.cof[l]) : req.cof[l]),
                                 {FRAC_BITS{1'b0}}};
            st_next[0].rem[l] = '0;
            st_next[0].neg[l] = req.cof[l][31] ^ req.det[31];
        end
    end

    // Each stage brings down one numerator bit and settles one quotient bit.
    for (genvar s = 1; s < NST; s++)
    begin : g_step
        always_comb
        begin : step
            logic [32:0] cat;
            logic        ge;
            st_next[s] = st_reg[s-1];
            for (int l = 0; l < NLANE; l++)
            begin
                cat = {st_reg[s-1].rem[l], st_reg[s-1].quo[l][QBITS-1]};
                ge  = cat >= {1'b0, st_reg[s-1].den};
                st_next[s].rem[l] = ge ? 32'(cat - {1'b0, st_reg[s-1].den}) : cat[31:0];
                st_next[s].quo[l] = {st_reg[s-1].quo[l][QBITS-2:0], ge};
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], req_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign rsp_valid = vld_reg[NST-1];
    assign rsp       = st_reg[NST-1];

    // A good status implies a non-zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.side.status == ST_OK |-> rsp.den != '0)
        else $error("divider: zero divisor on a good request");

    // The remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.den != '0 |-> rsp.rem[0] < rsp.den)
        else $error("divider: remainder not below divisor");

    // A held pipeline keeps its occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("divider: occupancy changed while held");

endmodule
